// ===== hdl/sarg_pkg.sv =====
// Package for the stepper ramp generator: function codes, register indexes,
// field widths and reset values. No dependencies.
package sarg_pkg;
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_MOVE = 2'd1;
   localparam logic [1:0] FUNC_SETPOS = 2'd2;

   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_INIT_IVL = 2'd1;
   localparam logic [1:0] REG_MIN_IVL = 2'd2;
   localparam logic [1:0] REG_BRAKE = 2'd3;

   localparam int ADDR_W = 5;
   localparam int DIV_NUM_W = 64;
   localparam int DIV_CNT_W = 7;

   localparam logic [31:0] INIT_IVL_RST = 32'd256000;
   localparam logic [31:0] MIN_IVL_RST = 32'd256000000;
   localparam logic [47:0] BRAKE_RST = 48'd500000000000;

   typedef struct packed {
      logic start;
      logic [63:0] num;
      logic [32:0] den;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [63:0] quo;
   } div_rsp_type;
endpackage

// ===== hdl/sarg_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
interface sarg_req_if;
   logic valid;
   logic ready;
   logic [1:0] func;
   logic signed [31:0] value;
   modport source (output valid, func, value, input ready);
   modport sink (input valid, func, value, output ready);
endinterface

interface sarg_rsp_if;
   logic valid;
   logic ready;
   logic step_pulse;
   logic direction;
   logic signed [31:0] position;
   logic at_target;
   logic [31:0] step_interval;
   modport source (output valid, step_pulse, direction, position, at_target, step_interval,
      input ready);
   modport sink (input valid, step_pulse, direction, position, at_target, step_interval,
      output ready);
endinterface

// ===== hdl/sarg_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, 64 / 33 bits.
// Depends on sarg_pkg.
module sarg_divider import sarg_pkg::*; (
   input logic clock,
   input logic reset,
   input div_req_type req,
   output div_rsp_type rsp
);
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [33:0] shifted;
   logic [34:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      shifted = {rem_ff[32:0], quo_ff[63]};
      diff = {1'b0, shifted} - {2'b00, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = req.num;
         rem_in = '0;
         den_in = req.den;
      end else if (busy_ff) begin
         if (!diff[34]) begin
            rem_in = diff[33:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;
endmodule

// ===== hdl/stepper_accel_ramp_generator.sv =====
// Top level of the stepper ramp generator: APB registers, sequencer, state.
// Depends on sarg_pkg, sarg_if and sarg_divider.
//
// channel  | dir | protocol  | payload
// req      | in  | valid/rdy | func, value
// rsp      | out | valid/rdy | step_pulse, direction, position, at_target, step_interval
// csr      | in  | APB       | four registers at 8*i
//
// A non-stepping tick or a set-position goes straight to the result state; a move
// or a stepping tick that recomputes uses up to three passes of the one shared divider.
// Reset is synchronous; the block is not ready while a transaction is in work or
// while its result waits on rsp.
module stepper_accel_ramp_generator import sarg_pkg::*; (
   input logic clock,
   input logic reset,
   sarg_req_if.sink req,
   sarg_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [ADDR_W-1:0] csr_paddr,
   input logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIST1 = 3'd1;
   localparam logic [2:0] S_DIST2 = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_TERM = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic en_ff;
   logic [31:0] init_ff, min_ff;
   logic [47:0] brake_ff;
   logic [2:0] st_ff, st_in;
   logic [31:0] pos_ff, pos_in, tgt_ff, tgt_in;
   logic signed [31:0] n_ff, n_in;
   logic [31:0] ramp_ff, ramp_in, act_ff, act_in, ticks_ff, ticks_in;
   logic rot_ff, rot_in, pulse_ff, pulse_in;
   logic [63:0] dist_ff, dist_in;
   logic wr_en;
   div_req_type dreq;
   div_rsp_type drsp;
   logic signed [32:0] delta;
   logic [32:0] mag;
   logic [31:0] negdist;
   logic signed [33:0] den4;
   logic [32:0] aden;
   logic [32:0] rsum;
   logic [31:0] rnew;
   logic signed [31:0] nsel;
   logic [1:0] reg_idx;

   sarg_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[ADDR_W-1:3];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2:0] == 3'd0);
   always_comb begin
      case (reg_idx)
         REG_ENABLE: csr_prdata = {63'd0, en_ff};
         REG_INIT_IVL: csr_prdata = {32'd0, init_ff};
         REG_MIN_IVL: csr_prdata = {32'd0, min_ff};
         REG_BRAKE: csr_prdata = {16'd0, brake_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b1;
         init_ff <= INIT_IVL_RST;
         min_ff <= MIN_IVL_RST;
         brake_ff <= BRAKE_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_ENABLE: en_ff <= csr_pwdata[0];
            REG_INIT_IVL: init_ff <= csr_pwdata[31:0];
            REG_MIN_IVL: min_ff <= csr_pwdata[31:0];
            REG_BRAKE: brake_ff <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = (st_ff == S_OUT);
   assign rsp.step_pulse = pulse_ff;
   assign rsp.direction = rot_ff;
   assign rsp.position = pos_ff;
   assign rsp.at_target = (pos_ff == tgt_ff);
   assign rsp.step_interval = act_ff;

   always_comb begin
      delta = $signed({tgt_ff[31], tgt_ff}) - $signed({pos_ff[31], pos_ff});
      mag = delta[32] ? 33'(-delta) : 33'(delta);
      negdist = (dist_ff > 64'h7FFF_FFFF) ? 32'h8000_0001 : 32'(-dist_ff[31:0]);
      nsel = n_ff;
      if (!delta[32]) begin
         if ((n_ff > 0 && dist_ff >= {31'd0, mag}) || rot_ff) nsel = $signed(negdist);
         else if (n_ff < 0 && dist_ff < {31'd0, mag} && !rot_ff) nsel = -n_ff;
      end else begin
         if ((n_ff > 0 && dist_ff >= {31'd0, mag}) || !rot_ff) nsel = $signed(negdist);
         else if (n_ff < 0 && dist_ff < {31'd0, mag} && rot_ff) nsel = -n_ff;
      end
      den4 = 34'(nsel) * 34'sd4 + 34'sd1;
      aden = den4[33] ? 33'(-den4) : 33'(den4);
      rsum = {1'b0, ramp_ff} + drsp.quo[32:0];
      if (n_ff[31]) begin
         rnew = (rsum[32] || (drsp.quo[63:33] != '0)) ? 32'hFFFF_FFFF : rsum[31:0];
      end else begin
         rnew = ramp_ff - drsp.quo[31:0];
      end
   end

   always_comb begin
      st_in = st_ff;
      pos_in = pos_ff; tgt_in = tgt_ff; n_in = n_ff; ramp_in = ramp_ff;
      act_in = act_ff; ticks_in = ticks_ff; rot_in = rot_ff;
      pulse_in = pulse_ff; dist_in = dist_ff;
      dreq = '0;
      case (st_ff)
         S_IDLE: begin
            if (req.valid) begin
               pulse_in = 1'b0;
               st_in = S_OUT;
               case (req.func)
                  FUNC_TICK: begin
                     ticks_in = (ticks_ff == 32'hFFFF_FFFF) ? ticks_ff : ticks_ff + 1'b1;
                     if (en_ff && act_ff != 0 && pos_ff != tgt_ff &&
                         {ticks_in, 8'd0} >= {8'd0, act_ff}) begin
                        pos_in = rot_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;
                        ticks_in = '0;
                        pulse_in = 1'b1;
                        st_in = S_DIST1;
                     end
                  end
                  FUNC_MOVE: begin
                     if (tgt_ff != req.value) begin
                        tgt_in = req.value;
                        st_in = S_DIST1;
                     end
                  end
                  FUNC_SETPOS: begin
                     pos_in = req.value; tgt_in = req.value;
                     ramp_in = '0; n_in = '0; act_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_DIST1: begin
            if (delta == 0) begin
               ramp_in = '0; act_in = '0; n_in = '0;
               st_in = S_OUT;
            end else if (ramp_ff == 0 || brake_ff == 0) begin
               dist_in = '0;
               st_in = S_DECIDE;
            end else begin
               dreq.start = 1'b1;
               dreq.num = {brake_ff, 16'd0};
               dreq.den = {1'b0, ramp_ff};
               st_in = S_DIST2;
            end
         end
         S_DIST2: begin
            if (drsp.done) begin
               if (dist_ff == 64'd1) begin
                  dist_in = drsp.quo;
                  st_in = S_DECIDE;
               end else begin
                  dist_in = 64'd1;
                  dreq.start = 1'b1;
                  dreq.num = drsp.quo;
                  dreq.den = {1'b0, ramp_ff};
               end
            end
         end
         S_DECIDE: begin
            n_in = nsel;
            if (nsel == 0) begin
               ramp_in = init_ff;
               rot_in = delta[32];
               st_in = S_FINISH;
            end else begin
               dreq.start = 1'b1;
               dreq.num = {31'd0, ramp_ff, 1'b0};
               dreq.den = 33'(aden);
               st_in = S_TERM;
            end
         end
         S_TERM: begin
            if (drsp.done) begin
               ramp_in = (rnew < min_ff) ? min_ff : rnew;
               st_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (n_ff != 32'sh7FFF_FFFF) n_in = n_ff + 32'sd1;
            act_in = ramp_ff;
            st_in = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_DIST1 && st_in == S_DIST2) dist_in = 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         pos_ff <= '0; tgt_ff <= '0; n_ff <= '0; ramp_ff <= '0;
         act_ff <= '0; ticks_ff <= '0; rot_ff <= 1'b0; pulse_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pos_ff <= pos_in; tgt_ff <= tgt_in; n_ff <= n_in; ramp_ff <= ramp_in;
         act_ff <= act_in; ticks_ff <= ticks_in; rot_ff <= rot_in; pulse_ff <= pulse_in;
      end
      dist_ff <= dist_in;
   end

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready while result pending");
   a_pulse_moves: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && $rose(rsp.valid) && rsp.step_pulse) |-> (act_ff != 0 || pos_ff == tgt_ff))
      else $error("step without interval");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE) |-> !drsp.busy) else $error("divider busy when idle");
endmodule
